// ===== design/jqns_pkg.sv =====
// Shared types and codes for the job queue next selector.
package jqns_pkg;

    localparam int JOB_W     = 16;
    localparam int OPCODE_W  = 3;
    localparam int QSEL_W    = 3;
    localparam int MODE_W    = 2;
    localparam int QCOUNT_W  = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 4;

    typedef struct packed {
        logic             blocked;
        logic [JOB_W-1:0] job_id;
    } t_entry;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND_QUEUE  = 3'd0,
        OP_APPEND_SYSTEM = 3'd1,
        OP_CLEAR         = 3'd2,
        OP_INIT          = 3'd3,
        OP_NEXT          = 3'd4
    } t_opcode;

    localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BY_QUEUE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLAT        = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_COUNT = 1'b1;

endpackage

// ===== design/jqns_entry_mem.sv =====
// Single-port-write, registered-read entry memory for job lists.
module jqns_entry_mem #(
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  jqns_pkg::t_entry i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output jqns_pkg::t_entry o_rdata
);
    import jqns_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/job_queue_next_selector.sv =====
// Top level: job list storage and next-job walk sequencer.
//
// Input channel (i_in_valid / o_in_stall) carries one command per transaction:
// append to a queue, append to the system list, clear lists, restart the walk,
// or ask for the next job. Every command gives exactly one result on the
// output channel (o_out_valid / i_out_stall): found, chosen job and list full.
// The user must let the configuration port write select_mode and queue_count
// only while idle; the block itself does not enforce this. One command is
// worked at a time. Appends, clear, restart and unused codes pass from accept
// through the done state to the result. A next request walks its list: each
// stored entry read takes a step state and a check state (a registered memory
// read, then the check); each queue skipped as empty or exhausted takes a step.
// The output holds one finished result in a register, so the next command is
// taken while that result waits; a further result waits in the sequencer
// until the receiver stops stalling. Synchronous reset empties all lists,
// restarts the walk, sets flat mode with one queue, and drops any result.
// Entry memories need no clearing: only entries below a list length are read.
module job_queue_next_selector #(
    parameter int MAX_QUEUES     = 8,
    parameter int JOBS_PER_QUEUE = 64,
    parameter int SYSTEM_JOBS    = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [jqns_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [jqns_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [jqns_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [jqns_pkg::QSEL_W-1:0]    i_queue_index,
    input  logic [jqns_pkg::JOB_W-1:0]     i_job_id,
    input  logic                           i_blocked,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_found,
    output logic [jqns_pkg::JOB_W-1:0]     o_chosen_job,
    output logic                           o_list_full
);
    import jqns_pkg::*;

    localparam int QW   = $clog2(MAX_QUEUES + 1);
    localparam int QIW  = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int LW   = $clog2(JOBS_PER_QUEUE + 1);
    localparam int SLW  = $clog2(SYSTEM_JOBS + 1);
    localparam int MAXS = (JOBS_PER_QUEUE > SYSTEM_JOBS) ? JOBS_PER_QUEUE : SYSTEM_JOBS;
    localparam int SW   = $clog2(MAXS + 1);
    localparam int QAW  = $clog2(MAX_QUEUES * JOBS_PER_QUEUE);
    localparam int SAW  = $clog2(SYSTEM_JOBS);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_RR_STEP  = 8'b0000_0010,
        ST_RR_CHECK = 8'b0000_0100,
        ST_BQ_STEP  = 8'b0000_1000,
        ST_BQ_CHECK = 8'b0001_0000,
        ST_FL_STEP  = 8'b0010_0000,
        ST_FL_CHECK = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [MODE_W-1:0]   r_select_mode, n_select_mode;
    logic [QCOUNT_W-1:0] r_queue_count, n_queue_count;
    logic [LW-1:0]       r_qlen [MAX_QUEUES];
    logic [LW-1:0]       n_qlen [MAX_QUEUES];
    logic [SLW-1:0]      r_sys_len, n_sys_len;
    logic [QW-1:0]       r_cur_queue, n_cur_queue;
    logic [SW-1:0]       r_cur_slot, n_cur_slot;
    logic [MAX_QUEUES-1:0] r_exhausted, n_exhausted;
    logic [QW-1:0]       r_iter, n_iter;
    logic                r_o_valid, n_o_valid;

    // payload
    logic             r_res_found, n_res_found;
    logic [JOB_W-1:0] r_res_job, n_res_job;
    logic             r_res_full, n_res_full;
    logic             r_o_found, n_o_found;
    logic [JOB_W-1:0] r_o_job, n_o_job;
    logic             r_o_full, n_o_full;

    // memory ports
    logic           q_we, s_we;
    logic [QAW-1:0] q_waddr, q_raddr;
    logic [SAW-1:0] s_waddr, s_raddr;
    t_entry         w_new_entry, q_rdata, s_rdata;

    logic            w_accept;
    logic [QW-1:0]   w_active;
    logic [4:0]      w_app_qi;
    logic            w_app_ok;
    logic [QIW-1:0]  w_app_q;
    logic [LW-1:0]   w_app_len;
    logic            w_rr_wrap;
    logic [QW-1:0]   w_rr_q;
    logic [QIW-1:0]  w_rr_qi;
    logic [SW-1:0]   w_rr_slot;
    logic            w_rr_empty;
    logic [QIW-1:0]  w_bq_qi;
    logic            w_bq_end;
    logic            w_bq_empty;
    logic            w_fl_end;
    logic [SW-1:0]   w_slot_sat_inc;
    logic [QIW-1:0]  w_probe_q;
    logic [SW-1:0]   w_probe_slot;
    logic            w_out_free;

    jqns_entry_mem #(.DEPTH(MAX_QUEUES * JOBS_PER_QUEUE)) u_queue_mem (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (w_new_entry),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    jqns_entry_mem #(.DEPTH(SYSTEM_JOBS)) u_system_mem (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (w_new_entry),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_out_free  = !r_o_valid || !i_out_stall;
    assign w_new_entry = '{blocked: i_blocked, job_id: i_job_id};

    always_comb begin
        if (32'(r_queue_count) < MAX_QUEUES) begin
            w_active = QW'(r_queue_count);
        end else begin
            w_active = QW'(MAX_QUEUES);
        end
    end

    // append targets
    assign w_app_qi  = {2'b00, i_queue_index};
    assign w_app_ok  = w_app_qi < 5'(MAX_QUEUES);
    assign w_app_q   = w_app_qi[QIW-1:0];
    assign w_app_len = r_qlen[w_app_q];
    assign q_waddr   = QAW'(w_app_q) * QAW'(JOBS_PER_QUEUE) + QAW'(w_app_len);
    assign s_waddr   = r_sys_len[SAW-1:0];

    // round robin: wrap to queue 0 bumps the shared slot index (saturating)
    assign w_rr_wrap  = r_cur_queue >= w_active;
    assign w_rr_q     = w_rr_wrap ? '0 : r_cur_queue;
    assign w_rr_qi    = w_rr_q[QIW-1:0];
    assign w_rr_slot  = (w_rr_wrap && (r_cur_slot < SW'(JOBS_PER_QUEUE))) ?
                        r_cur_slot + SW'(1) : r_cur_slot;
    assign w_rr_empty = w_rr_slot >= SW'(r_qlen[w_rr_qi]);

    assign w_bq_qi    = r_cur_queue[QIW-1:0];
    assign w_bq_end   = r_cur_queue >= w_active;
    assign w_bq_empty = r_cur_slot >= SW'(r_qlen[w_bq_qi]);

    assign w_fl_end   = r_cur_slot >= SW'(r_sys_len);

    assign w_slot_sat_inc = (r_cur_slot == SW'(MAXS)) ? r_cur_slot : r_cur_slot + SW'(1);

    assign w_probe_q    = (r_state == ST_RR_STEP) ? w_rr_qi : w_bq_qi;
    assign w_probe_slot = (r_state == ST_RR_STEP) ? w_rr_slot : r_cur_slot;
    assign q_raddr      = QAW'(w_probe_q) * QAW'(JOBS_PER_QUEUE) + QAW'(w_probe_slot);
    assign s_raddr      = r_cur_slot[SAW-1:0];

    always_comb begin
        n_state       = r_state;
        n_select_mode = r_select_mode;
        n_queue_count = r_queue_count;
        n_qlen        = r_qlen;
        n_sys_len     = r_sys_len;
        n_cur_queue   = r_cur_queue;
        n_cur_slot    = r_cur_slot;
        n_exhausted   = r_exhausted;
        n_iter        = r_iter;
        n_res_found   = r_res_found;
        n_res_job     = r_res_job;
        n_res_full    = r_res_full;
        n_o_valid     = r_o_valid;
        n_o_found     = r_o_found;
        n_o_job       = r_o_job;
        n_o_full      = r_o_full;
        q_we          = 1'b0;
        s_we          = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SELECT_MODE: n_select_mode = i_cfg_data[MODE_W-1:0];
                CFG_QUEUE_COUNT: n_queue_count = i_cfg_data[QCOUNT_W-1:0];
                default: ;
            endcase
        end

        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res_found = 1'b0;
                    n_res_job   = '0;
                    n_res_full  = 1'b0;
                    n_state     = ST_DONE;
                    unique case (i_opcode)
                        OP_APPEND_QUEUE: begin
                            if (w_app_ok) begin
                                if (w_app_len >= LW'(JOBS_PER_QUEUE)) begin
                                    n_res_full = 1'b1;
                                end else begin
                                    q_we             = 1'b1;
                                    n_qlen[w_app_q]  = w_app_len + LW'(1);
                                end
                            end
                        end
                        OP_APPEND_SYSTEM: begin
                            if (r_sys_len >= SLW'(SYSTEM_JOBS)) begin
                                n_res_full = 1'b1;
                            end else begin
                                s_we      = 1'b1;
                                n_sys_len = r_sys_len + SLW'(1);
                            end
                        end
                        OP_CLEAR: begin
                            for (int q = 0; q < MAX_QUEUES; q++) begin
                                n_qlen[q] = '0;
                            end
                            n_sys_len = '0;
                        end
                        OP_INIT: begin
                            n_cur_queue = '0;
                            n_cur_slot  = '0;
                            n_exhausted = '0;
                        end
                        OP_NEXT: begin
                            n_iter = '0;
                            case (r_select_mode)
                                MODE_ROUND_ROBIN: n_state = ST_RR_STEP;
                                MODE_BY_QUEUE:    n_state = ST_BQ_STEP;
                                default:          n_state = ST_FL_STEP;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            ST_RR_STEP: begin
                if (r_iter >= w_active) begin
                    n_state = ST_DONE;
                end else begin
                    n_cur_queue = w_rr_q + QW'(1);
                    n_cur_slot  = w_rr_slot;
                    n_iter      = r_iter + QW'(1);
                    if (r_exhausted[w_rr_qi]) begin
                        n_state = ST_RR_STEP;
                    end else if (w_rr_empty) begin
                        n_exhausted[w_rr_qi] = 1'b1;
                    end else begin
                        n_state = ST_RR_CHECK;
                    end
                end
            end
            ST_RR_CHECK: begin
                // a blocked slot is used up without giving a job
                if (q_rdata.blocked) begin
                    n_state = ST_RR_STEP;
                end else begin
                    n_res_found = 1'b1;
                    n_res_job   = q_rdata.job_id;
                    n_state     = ST_DONE;
                end
            end
            ST_BQ_STEP: begin
                if (w_bq_end) begin
                    n_cur_slot = w_slot_sat_inc;
                    n_state    = ST_DONE;
                end else if (w_bq_empty) begin
                    n_cur_queue = r_cur_queue + QW'(1);
                    n_cur_slot  = '0;
                end else begin
                    n_state = ST_BQ_CHECK;
                end
            end
            ST_BQ_CHECK: begin
                n_cur_slot = r_cur_slot + SW'(1);
                if (q_rdata.blocked) begin
                    n_state = ST_BQ_STEP;
                end else begin
                    n_res_found = 1'b1;
                    n_res_job   = q_rdata.job_id;
                    n_state     = ST_DONE;
                end
            end
            ST_FL_STEP: begin
                if (w_fl_end) begin
                    n_cur_slot = SW'(r_sys_len);
                    n_state    = ST_DONE;
                end else begin
                    n_state = ST_FL_CHECK;
                end
            end
            ST_FL_CHECK: begin
                n_cur_slot = r_cur_slot + SW'(1);
                if (s_rdata.blocked) begin
                    n_state = ST_FL_STEP;
                end else begin
                    n_res_found = 1'b1;
                    n_res_job   = s_rdata.job_id;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_found = r_res_found;
                    n_o_job   = r_res_job;
                    n_o_full  = r_res_full;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_select_mode <= MODE_FLAT;
            r_queue_count <= QCOUNT_W'(1);
            for (int q = 0; q < MAX_QUEUES; q++) begin
                r_qlen[q] <= '0;
            end
            r_sys_len   <= '0;
            r_cur_queue <= '0;
            r_cur_slot  <= '0;
            r_exhausted <= '0;
            r_iter      <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_select_mode <= n_select_mode;
            r_queue_count <= n_queue_count;
            r_qlen        <= n_qlen;
            r_sys_len     <= n_sys_len;
            r_cur_queue   <= n_cur_queue;
            r_cur_slot    <= n_cur_slot;
            r_exhausted   <= n_exhausted;
            r_iter        <= n_iter;
            r_o_valid     <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_found <= n_res_found;
        r_res_job   <= n_res_job;
        r_res_full  <= n_res_full;
        r_o_found   <= n_o_found;
        r_o_job     <= n_o_job;
        r_o_full    <= n_o_full;
    end

    assign o_out_valid  = r_o_valid;
    assign o_found      = r_o_found;
    assign o_chosen_job = r_o_job;
    assign o_list_full  = r_o_full;

endmodule

// ===== design/jqns_checker.sv =====
// Port-level checks for the job queue next selector, bound to the top level.
module jqns_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic                       o_found,
    input logic [jqns_pkg::JOB_W-1:0] o_chosen_job,
    input logic                       o_list_full
);
    import jqns_pkg::*;

    // reset drops any pending result
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result still valid after reset");

    // one command at a time: an accepted transaction keeps the input busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a transaction");

    a_no_job_when_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_chosen_job == '0))
        else $error("job id nonzero without a found job");

    a_found_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> !o_list_full)
        else $error("found and list full in one result");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable({o_found, o_chosen_job, o_list_full})))
        else $error("stalled result changed");

endmodule

bind job_queue_next_selector jqns_checker u_jqns_checker (.*);
